@@ hw/rtl/header_length_crc_frame_parser_macros.svh @@
// assertion macros for the header/length/crc frame parser
`ifndef HEADER_LENGTH_CRC_FRAME_PARSER_MACROS_SVH
`define HEADER_LENGTH_CRC_FRAME_PARSER_MACROS_SVH
`ifndef ASSERT_OFF
`define HLCFP_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define HLCFP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define HLCFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HLCFP_ASSERT(label, cond, msg)
`define HLCFP_ASSERT_IMPL(label, ante, cons, msg)
`define HLCFP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ hw/rtl/hlcfp_pkg.sv @@
// shared types, codes and crc helper for the frame parser
package hlcfp_pkg;

    typedef enum logic [2:0] {
        EV_BUSY    = 3'd0,
        EV_BYTE    = 3'd1,
        EV_GOOD    = 3'd2,
        EV_TOOLONG = 3'd3,
        EV_BADCRC  = 3'd4
    } event_t;

    // register indexes, taken from paddr[4:3]
    localparam logic [1:0] REG_HEADER_BYTES  = 2'd0;
    localparam logic [1:0] REG_HEADER_LENGTH = 2'd1;
    localparam logic [1:0] REG_CRC_ENABLE    = 2'd2;
    localparam logic [1:0] REG_PAYLOAD_LIMIT = 2'd3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [3:0]  HEADER_LENGTH_MIN   = 4'd2;
    localparam logic [3:0]  HEADER_LENGTH_RESET = 4'd2;
    localparam logic [15:0] PAYLOAD_LIMIT_RESET = 16'd256;

    // crc-16 ccitt, msb first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/header_length_crc_frame_parser.sv @@
// frame parser top level: sync header hunt, length, payload stream, crc-16 check
// the result of an accepted byte is in the output register the cycle after it
// throughput: one byte per cycle unless out_ready stalls a full result register,
// set by the byte-wide crc and state updates between the byte and the result register
// reset: rst_n clears the parser to hunting, empties the output register and loads
// the register defaults (header 0, header length 2, crc on, payload limit 256)
module header_length_crc_frame_parser
    import hlcfp_pkg::*;
#(
    parameter int unsigned HEADER_MAX_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,

    // apb-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,

    // received byte requests
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,

    // result requests
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_res,
    output logic [7:0]  payload_byte,
    output logic [15:0] payload_index,
    output logic [15:0] frame_len
);

    // header position counter only needs to address the header bytes
    localparam int unsigned MW = (HEADER_MAX_BYTES > 2) ? $clog2(HEADER_MAX_BYTES) : 1;
    localparam logic [3:0]  HMAX = 4'(HEADER_MAX_BYTES);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CRC
    } phase_t;

    // configuration registers
    logic [63:0] header_bytes_reg;
    logic [3:0]  header_length_reg;
    logic        crc_enable_reg;
    logic [15:0] payload_limit_reg;

    // parser state
    phase_t        phase_reg, phase_next;
    logic [MW-1:0] matched_reg, matched_next;
    logic [15:0]   declared_reg, declared_next;
    logic          second_reg, second_next;
    logic [15:0]   count_reg, count_next;
    logic [15:0]   crc_reg, crc_next;
    logic [7:0]    crc_high_reg, crc_high_next;

    // result register
    logic          out_valid_reg;
    event_t        event_reg, event_next;
    logic [7:0]    pbyte_reg, pbyte_next;
    logic [15:0]   pindex_reg, pindex_next;
    logic [15:0]   flen_reg, flen_next;

    logic          in_fire;
    logic          cfg_write;
    logic          idle_after;
    logic [3:0]    eff_len;
    logic [3:0]    matched_inc;
    logic [7:0]    hdr_first;
    logic [7:0]    hdr_cur;
    logic [15:0]   count_inc;
    logic [15:0]   length_full;

    // the result register parts the two sides: a new byte is taken whenever the
    // previous result is gone or leaves in this same cycle
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    assign out_valid     = out_valid_reg;
    assign event_res     = event_reg;
    assign payload_byte  = pbyte_reg;
    assign payload_index = pindex_reg;
    assign frame_len     = flen_reg;

    // register readback
    always_comb
    begin
        unique case (paddr[4:3])
            REG_HEADER_BYTES:  prdata = header_bytes_reg;
            REG_HEADER_LENGTH: prdata = {60'd0, header_length_reg};
            REG_CRC_ENABLE:    prdata = {63'd0, crc_enable_reg};
            REG_PAYLOAD_LIMIT: prdata = {48'd0, payload_limit_reg};
            default:           prdata = 64'd0;
        endcase
    end

    // header length clamped to the supported range
    always_comb
    begin
        priority if (header_length_reg < HEADER_LENGTH_MIN)
        begin
            eff_len = HEADER_LENGTH_MIN;
        end
        else if (header_length_reg > HMAX)
        begin
            eff_len = HMAX;
        end
        else
        begin
            eff_len = header_length_reg;
        end
    end

    assign hdr_first   = header_bytes_reg[7:0];
    assign hdr_cur     = header_bytes_reg[{matched_reg, 3'b000} +: 8];
    assign matched_inc = 4'(matched_reg) + 4'd1;
    assign count_inc   = count_reg + 16'd1;
    assign length_full = {declared_reg[15:8], rx_byte};

    // next state and result for the byte on the input
    always_comb
    begin
        phase_next    = phase_reg;
        matched_next  = matched_reg;
        declared_next = declared_reg;
        second_next   = second_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        crc_high_next = crc_high_reg;
        event_next    = EV_BUSY;
        pbyte_next    = 8'd0;
        pindex_next   = 16'd0;
        idle_after    = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (rx_byte == hdr_first)
                begin
                    crc_next     = crc16_byte(CRC_INIT, rx_byte);
                    matched_next = MW'(1);
                    phase_next   = PH_HEADER;
                end
            end
            PH_HEADER:
            begin
                if (rx_byte == hdr_cur)
                begin
                    crc_next = crc16_byte(crc_reg, rx_byte);
                    // a lowered header length ends the match as soon as it is reached
                    if (matched_inc >= eff_len)
                    begin
                        matched_next = '0;
                        phase_next   = PH_LENGTH;
                        second_next  = 1'b0;
                    end
                    else
                    begin
                        matched_next = matched_inc[MW-1:0];
                    end
                end
                else if (rx_byte == hdr_first)
                begin
                    // mismatch on a first header byte restarts the hunt
                    crc_next     = crc16_byte(CRC_INIT, rx_byte);
                    matched_next = MW'(1);
                end
                else
                begin
                    idle_after = 1'b1;
                end
            end
            PH_LENGTH:
            begin
                crc_next = crc16_byte(crc_reg, rx_byte);
                if (!second_reg)
                begin
                    declared_next = {rx_byte, 8'h00};
                    second_next   = 1'b1;
                end
                else
                begin
                    declared_next = length_full;
                    second_next   = 1'b0;
                    if (length_full > payload_limit_reg)
                    begin
                        event_next = EV_TOOLONG;
                        idle_after = 1'b1;
                    end
                    else if (length_full == 16'd0)
                    begin
                        // empty payload goes straight to the crc or the verdict
                        if (crc_enable_reg)
                        begin
                            phase_next = PH_CRC;
                        end
                        else
                        begin
                            event_next = EV_GOOD;
                            idle_after = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                        count_next = 16'd0;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                crc_next    = crc16_byte(crc_reg, rx_byte);
                event_next  = EV_BYTE;
                pbyte_next  = rx_byte;
                pindex_next = count_reg;
                count_next  = count_inc;
                if (count_inc >= declared_reg)
                begin
                    count_next    = 16'd0;
                    second_next   = 1'b0;
                    crc_high_next = 8'd0;
                    if (crc_enable_reg)
                    begin
                        phase_next = PH_CRC;
                    end
                    else
                    begin
                        // last byte still carries its value and index with the verdict
                        event_next = EV_GOOD;
                        idle_after = 1'b1;
                    end
                end
            end
            PH_CRC:
            begin
                if (!second_reg)
                begin
                    crc_high_next = rx_byte;
                    second_next   = 1'b1;
                end
                else
                begin
                    event_next = ({crc_high_reg, rx_byte} == crc_reg) ? EV_GOOD : EV_BADCRC;
                    idle_after = 1'b1;
                end
            end
            default:
            begin
                idle_after = 1'b1;
            end
        endcase

        // frame length reports the length before any return to hunting
        flen_next = declared_next;

        if (idle_after)
        begin
            phase_next    = PH_IDLE;
            matched_next  = '0;
            declared_next = 16'd0;
            second_next   = 1'b0;
            count_next    = 16'd0;
            crc_next      = 16'd0;
            crc_high_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_bytes_reg  <= 64'd0;
            header_length_reg <= HEADER_LENGTH_RESET;
            crc_enable_reg    <= 1'b1;
            payload_limit_reg <= PAYLOAD_LIMIT_RESET;
            phase_reg         <= PH_IDLE;
            matched_reg       <= '0;
            declared_reg      <= 16'd0;
            second_reg        <= 1'b0;
            count_reg         <= 16'd0;
            crc_reg           <= 16'd0;
            crc_high_reg      <= 8'd0;
            out_valid_reg     <= 1'b0;
            event_reg         <= EV_BUSY;
            pbyte_reg         <= 8'd0;
            pindex_reg        <= 16'd0;
            flen_reg          <= 16'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (paddr[4:3])
                    REG_HEADER_BYTES:  header_bytes_reg  <= pwdata;
                    REG_HEADER_LENGTH: header_length_reg <= pwdata[3:0];
                    REG_CRC_ENABLE:    crc_enable_reg    <= pwdata[0];
                    REG_PAYLOAD_LIMIT: payload_limit_reg <= pwdata[15:0];
                    default:           header_bytes_reg  <= header_bytes_reg;
                endcase
            end

            if (in_fire)
            begin
                phase_reg     <= phase_next;
                matched_reg   <= matched_next;
                declared_reg  <= declared_next;
                second_reg    <= second_next;
                count_reg     <= count_next;
                crc_reg       <= crc_next;
                crc_high_reg  <= crc_high_next;
                out_valid_reg <= 1'b1;
                event_reg     <= event_next;
                pbyte_reg     <= pbyte_next;
                pindex_reg    <= pindex_next;
                flen_reg      <= flen_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`include "header_length_crc_frame_parser_macros.svh"

    // hunting means all frame state is cleared
    `HLCFP_ASSERT_IMPL(a_idle_clear, phase_reg == PH_IDLE, declared_reg == 16'd0 && count_reg == 16'd0 && second_reg == 1'b0, "frame state not cleared while hunting")

    // a verdict always sends the parser back to hunting
    `HLCFP_ASSERT_NEXT(a_verdict_idle, in_fire && (event_next == EV_GOOD || event_next == EV_TOOLONG || event_next == EV_BADCRC), phase_reg == PH_IDLE, "no return to hunting after a verdict")

    // payload bytes only come out of the payload phase
    `HLCFP_ASSERT_IMPL(a_byte_phase, in_fire && event_next == EV_BYTE, phase_reg == PH_PAYLOAD, "payload byte outside payload phase")

    // payload index stays below the declared length
    `HLCFP_ASSERT_IMPL(a_count_range, phase_reg == PH_PAYLOAD, count_reg < declared_reg, "payload count past declared length")

    // a stalled result is held until taken
    `HLCFP_ASSERT_NEXT(a_result_hold, out_valid_reg && !out_ready, out_valid_reg && $stable(event_reg) && $stable(flen_reg), "stalled result changed")

endmodule
